>>> hdl/rpn_pkg.sv
`timescale 1ns / 1ps
// rpn_pkg: shared types, sizes and codes for the rpn stack evaluator
// depends on nothing; used by rpn_alu, rpn_stack_evaluator_unit and tb

package rpn_pkg;

    localparam int STACK_DEPTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int WORD_W        = 32;
    localparam int DEPTH_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W        = $clog2(STACK_DEPTH);
    localparam int CNT_W         = $clog2(WORD_W);

    localparam logic [2:0] CMD_PUSH    = 3'd0;
    localparam logic [2:0] CMD_ADD     = 3'd1;
    localparam logic [2:0] CMD_SUB     = 3'd2;
    localparam logic [2:0] CMD_MUL     = 3'd3;
    localparam logic [2:0] CMD_DIV     = 3'd4;
    localparam logic [2:0] CMD_INVALID = 3'd5;
    localparam logic [2:0] CMD_END     = 3'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_DIVZERO   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;
    localparam logic [2:0] ST_TOOFEW    = 3'd5;
    localparam logic [2:0] ST_TOOMANY   = 3'd6;

    localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        logic [2:0]               command;
        logic signed [WORD_W-1:0] operand_value;
    } cmd_word_t;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [WORD_W-1:0] final_value;
    } res_word_t;

    typedef struct packed {
        logic              start;
        logic [2:0]        op;
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } alu_rsp_t;

endpackage

>>> hdl/rpn_ram.sv
`timescale 1ns / 1ps
// rpn_ram: generic single write port ram with one registered read port
// depends on nothing

module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/rpn_alu.sv
`timescale 1ns / 1ps
// rpn_alu: saturating fixed point add, subtract, multiply and bit-serial divide
// depends on rpn_pkg

module rpn_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  rpn_pkg::alu_req_t req,
    output rpn_pkg::alu_rsp_t rsp
);

    localparam int W = rpn_pkg::WORD_W;

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_MUL  = 3'd1;
    localparam logic [2:0] A_DPRE = 3'd2;
    localparam logic [2:0] A_DIV  = 3'd3;
    localparam logic [2:0] A_FIN  = 3'd4;

    logic [2:0]                  state_reg, state_next;
    logic [W-1:0]                mag_a_reg, mag_a_next;
    logic [W-1:0]                mag_b_reg, mag_b_next;
    logic                        neg_reg, neg_next;
    logic [2*W-1:0]              mag_reg, mag_next;
    logic [W-1:0]                rem_reg, rem_next;
    logic [W-1:0]                quo_reg, quo_next;
    logic [rpn_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [W-1:0]                result_reg, result_next;
    logic                        done_reg, done_next;

    logic [W-1:0]   abs_l, abs_r, hi_part;
    logic [W:0]     sum, diff, rem_sh, rem_sub;
    logic [2*W-1:0] prod;
    logic           take;

    assign abs_l   = req.left[W-1]  ? (~req.left + W'(1))  : req.left;
    assign abs_r   = req.right[W-1] ? (~req.right + W'(1)) : req.right;
    assign sum     = {req.left[W-1], req.left} + {req.right[W-1], req.right};
    assign diff    = {req.left[W-1], req.left} - {req.right[W-1], req.right};
    assign prod    = mag_a_reg * mag_b_reg;
    assign hi_part = mag_a_reg >> (W - rpn_pkg::FRACTION_BITS);
    assign rem_sh  = {rem_reg, quo_reg[W-1]};
    assign rem_sub = rem_sh - {1'b0, mag_b_reg};
    assign take    = rem_sh >= {1'b0, mag_b_reg};

    function automatic logic [W-1:0] sat33(input logic [W:0] v);
        logic [W-1:0] r;
        if (v[W] != v[W-1])
        begin
            r = v[W] ? rpn_pkg::WORD_MIN : rpn_pkg::WORD_MAX;
        end
        else
        begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    always_comb
    begin
        state_next  = state_reg;
        mag_a_next  = mag_a_reg;
        mag_b_next  = mag_b_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    mag_a_next = abs_l;
                    mag_b_next = abs_r;
                    neg_next   = req.left[W-1] ^ req.right[W-1];
                    case (req.op) inside
                        rpn_pkg::CMD_ADD:
                        begin
                            result_next = sat33(sum);
                            done_next   = 1'b1;
                        end
                        rpn_pkg::CMD_SUB:
                        begin
                            result_next = sat33(diff);
                            done_next   = 1'b1;
                        end
                        rpn_pkg::CMD_MUL:
                        begin
                            state_next = A_MUL;
                        end
                        default:
                        begin
                            state_next = A_DPRE;
                        end
                    endcase
                end
            end
            A_MUL:
            begin
                mag_next   = prod >> rpn_pkg::FRACTION_BITS;
                state_next = A_FIN;
            end
            A_DPRE:
            begin
                if (hi_part >= mag_b_reg)
                begin
                    // quotient does not fit the word
                    mag_next   = {{(W-1){1'b0}}, 1'b1, {W{1'b0}}};
                    state_next = A_FIN;
                end
                else
                begin
                    rem_next   = hi_part;
                    quo_next   = W'(mag_a_reg << rpn_pkg::FRACTION_BITS);
                    cnt_next   = {rpn_pkg::CNT_W{1'b1}};
                    state_next = A_DIV;
                end
            end
            A_DIV:
            begin
                rem_next = take ? rem_sub[W-1:0] : rem_sh[W-1:0];
                quo_next = {quo_reg[W-2:0], take};
                cnt_next = cnt_reg - rpn_pkg::CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    mag_next   = {{W{1'b0}}, quo_reg[W-2:0], take};
                    state_next = A_FIN;
                end
            end
            A_FIN:
            begin
                if (neg_reg)
                begin
                    result_next = (mag_reg > {{W{1'b0}}, rpn_pkg::WORD_MIN}) ?
                                  rpn_pkg::WORD_MIN : (~mag_reg[W-1:0] + W'(1));
                end
                else
                begin
                    result_next = (mag_reg > {{W{1'b0}}, rpn_pkg::WORD_MAX}) ?
                                  rpn_pkg::WORD_MAX : mag_reg[W-1:0];
                end
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_a_reg  <= mag_a_next;
        mag_b_reg  <= mag_b_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

>>> hdl/rpn_stack_evaluator_unit.sv
`timescale 1ns / 1ps
// rpn_stack_evaluator_unit: reverse-polish evaluator top level with operand stack
// depends on rpn_pkg, rpn_ram and rpn_alu
//
// usage:
//   cmd channel (cmd_valid/cmd_ready/cmd_word) takes one token word at a time:
//   push number, add, subtract, multiply, divide, invalid token or end.
//   res channel (res_valid/res_ready/res_word) gives one word per end token
//   with the status and the final value.
// token handling:
//   push, invalid and ignored tokens are handled without leaving the idle state.
//   add, subtract, multiply and divide do two stack reads, then use the shared
//   alu unless a divide has a zero divisor; divide runs one quotient bit per cycle, 32 steps.
//   an end token does one stack read before its result word is
//   registered; cmd_ready is low while a token is being worked on.
// reset:
//   the stack is empty and no error is held; stack contents stay unknown.
// stall:
//   a waiting result word holds while res_ready is low; tokens other than end
//   are still taken, a second end token waits until the first word leaves.

module rpn_stack_evaluator_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  rpn_pkg::cmd_word_t cmd_word,
    output logic               res_valid,
    input  logic               res_ready,
    output rpn_pkg::res_word_t res_word
);

    localparam int W  = rpn_pkg::WORD_W;
    localparam int DW = rpn_pkg::DEPTH_W;
    localparam int AW = rpn_pkg::ADDR_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDB  = 3'd1;
    localparam logic [2:0] S_RDA  = 3'd2;
    localparam logic [2:0] S_CALC = 3'd3;
    localparam logic [2:0] S_END  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [DW-1:0]      depth_reg, depth_next;
    logic [2:0]         held_reg, held_next;
    logic [2:0]         op_reg, op_next;
    logic [W-1:0]       b_reg, b_next;
    logic               res_valid_reg, res_valid_next;
    rpn_pkg::res_word_t res_word_reg, res_word_next;

    logic               cmd_fire;
    logic [DW-1:0]      depth_m1, depth_m2;
    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [W-1:0]       wdata, rdata;
    rpn_pkg::alu_req_t  alu_req;
    rpn_pkg::alu_rsp_t  alu_rsp;

    assign cmd_ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd_valid & cmd_ready;
    assign depth_m1  = depth_reg - DW'(1);
    assign depth_m2  = depth_reg - DW'(2);
    assign raddr     = (state_reg == S_RDB) ? depth_m2[AW-1:0] : depth_m1[AW-1:0];

    rpn_ram #(
        .WIDTH(W),
        .DEPTH(rpn_pkg::STACK_DEPTH)
    ) u_stack (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    rpn_alu u_alu (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (alu_req),
        .rsp  (alu_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        held_next      = held_reg;
        op_next        = op_reg;
        b_next         = b_reg;
        res_valid_next = res_valid_reg & ~res_ready;
        res_word_next  = res_word_reg;
        we             = 1'b0;
        waddr          = depth_reg[AW-1:0];
        wdata          = cmd_word.operand_value;
        alu_req.start  = 1'b0;
        alu_req.op     = op_reg;
        alu_req.left   = rdata;
        alu_req.right  = b_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd_word.command == rpn_pkg::CMD_END)
                    begin
                        state_next = S_END;
                    end
                    else if (held_reg == rpn_pkg::ST_OK)
                    begin
                        case (cmd_word.command) inside
                            rpn_pkg::CMD_PUSH:
                            begin
                                if (depth_reg >= DW'(rpn_pkg::STACK_DEPTH))
                                begin
                                    held_next = rpn_pkg::ST_OVERFLOW;
                                end
                                else
                                begin
                                    we         = 1'b1;
                                    depth_next = depth_reg + DW'(1);
                                end
                            end
                            rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB,
                            rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV:
                            begin
                                if (depth_reg < DW'(2))
                                begin
                                    held_next = rpn_pkg::ST_UNDERFLOW;
                                end
                                else
                                begin
                                    op_next    = cmd_word.command;
                                    state_next = S_RDB;
                                end
                            end
                            default:
                            begin
                                held_next = rpn_pkg::ST_INVALID;
                            end
                        endcase
                    end
                end
            end
            S_RDB:
            begin
                b_next     = rdata;
                state_next = S_RDA;
            end
            S_RDA:
            begin
                if (op_reg == rpn_pkg::CMD_DIV && b_reg == '0)
                begin
                    held_next  = rpn_pkg::ST_DIVZERO;
                    state_next = S_IDLE;
                end
                else
                begin
                    alu_req.start = 1'b1;
                    state_next    = S_CALC;
                end
            end
            S_CALC:
            begin
                waddr = depth_m2[AW-1:0];
                wdata = alu_rsp.result;
                if (alu_rsp.done)
                begin
                    we         = 1'b1;
                    depth_next = depth_m1;
                    state_next = S_IDLE;
                end
            end
            S_END:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next            = 1'b1;
                    res_word_next.final_value = '0;
                    if (held_reg != rpn_pkg::ST_OK)
                    begin
                        res_word_next.status = held_reg;
                    end
                    else if (depth_reg == '0)
                    begin
                        res_word_next.status = rpn_pkg::ST_TOOFEW;
                    end
                    else if (depth_reg > DW'(1))
                    begin
                        res_word_next.status = rpn_pkg::ST_TOOMANY;
                    end
                    else
                    begin
                        res_word_next.status      = rpn_pkg::ST_OK;
                        res_word_next.final_value = rdata;
                    end
                    depth_next = '0;
                    held_next  = rpn_pkg::ST_OK;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            held_reg      <= rpn_pkg::ST_OK;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            held_reg      <= held_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        b_reg        <= b_next;
        res_word_reg <= res_word_next;
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for rpn_stack_evaluator_unit, directed expressions then random ones
// depends on rpn_pkg and the rpn_stack_evaluator_unit rtl

module tb;

    localparam int                         W              = rpn_pkg::WORD_W;
    localparam logic [2:0]                 CMD_UNUSED     = 3'd7;
    localparam logic [W-1:0]               Q_ONE          = 32'h0001_0000;
    localparam longint                     WORD_HI        = 64'sd2147483647;
    localparam longint                     WORD_LO        = -64'sd2147483648;
    localparam int                         WATCHDOG_LIMIT = 2000;
    localparam int                         TAIL_CYCLES    = 60;
    localparam logic [2:0]                 ARITH_OPS [4]  = '{rpn_pkg::CMD_ADD,
                                                              rpn_pkg::CMD_SUB,
                                                              rpn_pkg::CMD_MUL,
                                                              rpn_pkg::CMD_DIV};

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_ready;
    rpn_pkg::cmd_word_t cmd_word = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    rpn_pkg::res_word_t res_word;

    logic signed [W-1:0] eval_stack [rpn_pkg::STACK_DEPTH];
    int unsigned         eval_depth = 0;
    logic [2:0]          eval_error = rpn_pkg::ST_OK;
    rpn_pkg::res_word_t  pending_results [$];

    int unsigned mismatches = 0;
    int unsigned tokens_sent = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_left = 0;
    bit          quiet_run = 1'b0;

    rpn_stack_evaluator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word)
    );

    always #2 clk = ~clk;

    function automatic logic [W-1:0] clamp_word(longint v);
        if (v > WORD_HI)
            return rpn_pkg::WORD_MAX;
        if (v < WORD_LO)
            return rpn_pkg::WORD_MIN;
        return v[W-1:0];
    endfunction

    // token-level model of the evaluator
    task automatic evaluate_token(rpn_pkg::cmd_word_t word);
        longint             lhs;
        longint             rhs;
        longint             acc;
        longint             scale;
        rpn_pkg::res_word_t outcome;
        scale = longint'(1) << rpn_pkg::FRACTION_BITS;
        if (word.command == rpn_pkg::CMD_END)
        begin
            outcome.status      = eval_error;
            outcome.final_value = '0;
            if (eval_error == rpn_pkg::ST_OK)
            begin
                if (eval_depth == 0)
                    outcome.status = rpn_pkg::ST_TOOFEW;
                else if (eval_depth > 1)
                    outcome.status = rpn_pkg::ST_TOOMANY;
                else
                    outcome.final_value = eval_stack[0];
            end
            pending_results.push_back(outcome);
            eval_depth = 0;
            eval_error = rpn_pkg::ST_OK;
            return;
        end
        if (eval_error != rpn_pkg::ST_OK)
            return;
        case (word.command) inside
            rpn_pkg::CMD_PUSH:
            begin
                if (eval_depth >= rpn_pkg::STACK_DEPTH)
                    eval_error = rpn_pkg::ST_OVERFLOW;
                else
                begin
                    eval_stack[eval_depth] = word.operand_value;
                    eval_depth++;
                end
            end
            rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV:
            begin
                if (eval_depth < 2)
                begin
                    eval_error = rpn_pkg::ST_UNDERFLOW;
                    return;
                end
                rhs = eval_stack[eval_depth-1];
                lhs = eval_stack[eval_depth-2];
                case (word.command)
                    rpn_pkg::CMD_ADD: acc = lhs + rhs;
                    rpn_pkg::CMD_SUB: acc = lhs - rhs;
                    rpn_pkg::CMD_MUL: acc = (lhs * rhs) / scale;
                    default:
                    begin
                        if (rhs == 0)
                        begin
                            eval_error = rpn_pkg::ST_DIVZERO;
                            return;
                        end
                        acc = (lhs * scale) / rhs;
                    end
                endcase
                eval_depth--;
                eval_stack[eval_depth-1] = clamp_word(acc);
            end
            default: eval_error = rpn_pkg::ST_INVALID;
        endcase
    endtask

    function automatic void note_mismatch(string what, logic [34:0] want, logic [34:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h got %h at %0t", what, want, got, $time);
    endfunction

    // result word checker
    always @(posedge clk)
    begin
        rpn_pkg::res_word_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
                note_mismatch("unexpected word", '0, res_word);
            else
            begin
                want = pending_results.pop_front();
                if (res_word.status !== want.status)
                    note_mismatch("status", 35'(want.status), 35'(res_word.status));
                if (res_word.final_value !== want.final_value)
                    note_mismatch("final_value", 35'(want.final_value),
                                  35'(res_word.final_value));
            end
        end
    end

    // receiver stalls in random bursts
    always @(posedge clk)
    begin
        if (!quiet_run && stall_left == 0 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 15);
        res_ready <= (stall_left == 0);
        if (stall_left != 0)
            stall_left--;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic hold_sender(int unsigned cycles);
        cmd_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_token(logic [2:0] cmd, logic [W-1:0] value);
        rpn_pkg::cmd_word_t word;
        word = '{command: cmd, operand_value: value};
        if (!quiet_run && $urandom_range(0, 7) == 0)
            hold_sender($urandom_range(1, 15));
        cmd_valid <= 1'b1;
        cmd_word  <= word;
        do
            @(posedge clk);
        while (!cmd_ready);
        evaluate_token(word);
        tokens_sent++;
    endtask

    // stop sending and wait for every result word
    task automatic drain_results();
        hold_sender(1);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [W-1:0] rand_operand();
        logic [W-1:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 9)) inside
            0: return rpn_pkg::WORD_MAX;
            1: return rpn_pkg::WORD_MIN;
            2: return '0;
            3: return Q_ONE;
            4: return -Q_ONE;
            5, 6: return {{12{raw[19]}}, raw[19:0]};
            default: return raw;
        endcase
    endfunction

    // well-formed expression, never deeper than peak
    task automatic send_expression(int unsigned peak);
        int unsigned live;
        int unsigned pushed;
        int unsigned wanted;
        live   = 0;
        pushed = 0;
        wanted = $urandom_range(1, peak);
        while (!(pushed == wanted && live == 1))
        begin
            if (live >= 2 && (pushed == wanted || live >= peak || $urandom_range(0, 1) == 0))
            begin
                send_token(ARITH_OPS[$urandom_range(0, 3)], $urandom);
                live--;
            end
            else
            begin
                send_token(rpn_pkg::CMD_PUSH, rand_operand());
                pushed++;
                live++;
            end
        end
        send_token(rpn_pkg::CMD_END, $urandom);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_token(3'($urandom_range(0, 7)), rand_operand());
        send_token(rpn_pkg::CMD_END, $urandom);
    endtask

    task automatic test_saturation();
        send_token(rpn_pkg::CMD_PUSH, rpn_pkg::WORD_MAX);
        send_token(rpn_pkg::CMD_PUSH, rpn_pkg::WORD_MAX);
        send_token(rpn_pkg::CMD_ADD, '0);
        send_token(rpn_pkg::CMD_END, '0);
        send_token(rpn_pkg::CMD_PUSH, rpn_pkg::WORD_MIN);
        send_token(rpn_pkg::CMD_PUSH, Q_ONE);
        send_token(rpn_pkg::CMD_SUB, '0);
        send_token(rpn_pkg::CMD_END, '0);
        send_token(rpn_pkg::CMD_PUSH, rpn_pkg::WORD_MAX);
        send_token(rpn_pkg::CMD_PUSH, rpn_pkg::WORD_MAX);
        send_token(rpn_pkg::CMD_MUL, '0);
        send_token(rpn_pkg::CMD_END, '0);
        send_token(rpn_pkg::CMD_PUSH, rpn_pkg::WORD_MIN);
        send_token(rpn_pkg::CMD_PUSH, '1);
        send_token(rpn_pkg::CMD_DIV, '0);
        send_token(rpn_pkg::CMD_END, '0);
        drain_results();
    endtask

    task automatic test_error_cases();
        send_token(rpn_pkg::CMD_PUSH, Q_ONE);
        send_token(rpn_pkg::CMD_PUSH, '0);
        send_token(rpn_pkg::CMD_DIV, '0);
        send_token(rpn_pkg::CMD_END, '0);
        send_token(rpn_pkg::CMD_ADD, '0);
        send_token(rpn_pkg::CMD_END, '0);
        send_token(rpn_pkg::CMD_END, '0);
        send_token(rpn_pkg::CMD_PUSH, Q_ONE);
        send_token(rpn_pkg::CMD_PUSH, Q_ONE);
        send_token(rpn_pkg::CMD_END, '0);
        send_token(rpn_pkg::CMD_INVALID, '0);
        send_token(rpn_pkg::CMD_PUSH, Q_ONE);
        send_token(rpn_pkg::CMD_END, '0);
        send_token(CMD_UNUSED, '1);
        send_token(rpn_pkg::CMD_END, '0);
        drain_results();
    endtask

    task automatic test_stack_limits();
        repeat (rpn_pkg::STACK_DEPTH) send_token(rpn_pkg::CMD_PUSH, rand_operand());
        repeat (rpn_pkg::STACK_DEPTH - 1) send_token(ARITH_OPS[$urandom_range(0, 2)], $urandom);
        send_token(rpn_pkg::CMD_END, '0);
        repeat (rpn_pkg::STACK_DEPTH + 1) send_token(rpn_pkg::CMD_PUSH, rand_operand());
        send_token(rpn_pkg::CMD_PUSH, rand_operand());
        send_token(rpn_pkg::CMD_ADD, '0);
        send_token(rpn_pkg::CMD_END, '0);
        repeat (rpn_pkg::STACK_DEPTH) send_token(rpn_pkg::CMD_PUSH, rand_operand());
        send_token(rpn_pkg::CMD_END, '0);
        drain_results();
    endtask

    task automatic test_random_expressions();
        while (tokens_sent < 1150)
        begin
            case ($urandom_range(0, 9)) inside
                0: send_expression($urandom_range(2, rpn_pkg::STACK_DEPTH));
                1, 2: send_noise();
                default: send_expression($urandom_range(2, 5));
            endcase
            if ($urandom_range(0, 31) == 0)
                drain_results();
        end
        drain_results();
    endtask

    task automatic test_back_to_back();
        int unsigned stop_at;
        quiet_run = 1'b1;
        stop_at   = tokens_sent + 150;
        while (tokens_sent < stop_at)
        begin
            if ($urandom_range(0, 7) == 0)
                send_noise();
            else
                send_expression($urandom_range(2, 6));
        end
        drain_results();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_saturation();
        test_error_cases();
        test_stack_limits();
        test_random_expressions();
        test_back_to_back();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
